### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ipv4hc_pkg.sv
// ---------------------------------------------------------------------------
// IPv4 header check package
// Verdict codes, header offsets and the result type.
// ---------------------------------------------------------------------------
`default_nettype none

package ipv4hc_pkg;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT   = 3'd0,
        VERDICT_VERSION  = 3'd1,
        VERDICT_HEADLEN  = 3'd2,
        VERDICT_TTL      = 3'd3,
        VERDICT_DEST     = 3'd4,
        VERDICT_CHECKSUM = 3'd5
    } t_verdict;

    typedef struct packed {
        t_verdict   verdict;
        logic [3:0] header_words;
    } t_result;

    localparam int          ADDR_W         = 2;
    localparam logic [1:0]  REG_LOCAL_ADDR = 2'd0;

    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [5:0]  POS_FIRST      = 6'd0;
    localparam logic [5:0]  POS_TTL        = 6'd8;
    localparam logic [5:0]  POS_CSUM_LO    = 6'd11;
    localparam logic [5:0]  POS_DEST_FIRST = 6'd16;
    localparam logic [5:0]  POS_DEST_LAST  = 6'd19;
    localparam logic [5:0]  POS_LIMIT      = 6'd60;
    localparam logic [31:0] BCAST_ADDR     = 32'hffff_ffff;

endpackage

`default_nettype wire

### hw/rtl/ipv4_header_check.sv
// ---------------------------------------------------------------------------
// IPv4 header check
// A header's verdict comes out of the result queue, after the input register and the parser.
// Throughput: one byte per unstalled cycle; input register, parser, 2-entry result queue.
// The input stalls only while the result queue is full and the input register holds an item.
// Reset: synchronous, active low; local address 0, parser waits for a start.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv4_header_check (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [ipv4hc_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [7:0]                     i_data_byte,
    input  wire                            i_start_of_packet,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [2:0]                     o_verdict,
    output logic [3:0]                     o_header_words
);
    import ipv4hc_pkg::*;

    logic [31:0] r_local_addr;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_sop;
    logic        full;
    logic        go;
    logic        push;
    t_result     result;
    t_result     out_result;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
        end else if (psel && penable && pwrite && paddr == REG_LOCAL_ADDR) begin
            r_local_addr <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LOCAL_ADDR) ? r_local_addr : 32'd0;

    // input register
    assign go         = r_in_valid && !full;
    assign o_in_stall = r_in_valid && full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_sop  <= i_start_of_packet;
        end
    end

    ipv4hc_parse u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_go              (go),
        .i_data_byte       (r_in_byte),
        .i_start_of_packet (r_in_sop),
        .i_local_address   (r_local_addr),
        .o_push            (push),
        .o_result          (result)
    );

    ipv4hc_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_verdict      = out_result.verdict;
    assign o_header_words = out_result.header_words;

endmodule

`default_nettype wire

### hw/rtl/ipv4hc_parse.sv
// ---------------------------------------------------------------------------
// IPv4 header check: header parser
// Per-byte field checks, checksum accumulation and verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv4hc_parse (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_go,
    input  wire  [7:0]             i_data_byte,
    input  wire                    i_start_of_packet,
    input  wire  [31:0]            i_local_address,
    output logic                   o_push,
    output ipv4hc_pkg::t_result    o_result
);
    import ipv4hc_pkg::*;
    `include "assert_macros.svh"

    logic [5:0]  r_count,   n_count;
    logic [3:0]  r_ihl,     n_ihl;
    t_verdict    r_pending, n_pending;
    logic [31:0] r_dest,    n_dest;
    logic [15:0] r_sum,     n_sum;
    logic [7:0]  r_high,    n_high;
    logic [15:0] r_rxcsum,  n_rxcsum;
    logic        r_done,    n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ihl     <= '0;
            r_pending <= VERDICT_ACCEPT;
            r_dest    <= '0;
            r_sum     <= '0;
            r_high    <= '0;
            r_rxcsum  <= '0;
            r_done    <= 1'b1;
        end else if (i_go) begin
            r_count   <= n_count;
            r_ihl     <= n_ihl;
            r_pending <= n_pending;
            r_dest    <= n_dest;
            r_sum     <= n_sum;
            r_high    <= n_high;
            r_rxcsum  <= n_rxcsum;
            r_done    <= n_done;
        end
    end

    always_comb begin
        logic [5:0]  last;
        logic [15:0] word;
        logic [16:0] acc;
        logic        hit;
        t_verdict    verdict;

        n_count   = r_count;
        n_ihl     = r_ihl;
        n_pending = r_pending;
        n_dest    = r_dest;
        n_sum     = r_sum;
        n_high    = r_high;
        n_rxcsum  = r_rxcsum;
        n_done    = r_done;
        hit       = 1'b0;
        verdict   = VERDICT_ACCEPT;
        word      = {r_high, i_data_byte};
        acc       = '0;
        last      = '0;

        if (i_start_of_packet) begin
            n_count   = '0;
            n_pending = VERDICT_ACCEPT;
            n_dest    = '0;
            n_sum     = '0;
            n_high    = '0;
            n_rxcsum  = '0;
            n_done    = 1'b0;
        end

        if (!n_done) begin
            if (n_count == POS_FIRST) begin
                n_ihl = i_data_byte[3:0];
                if (i_data_byte[7:4] != IP_VERSION) begin
                    hit     = 1'b1;
                    verdict = VERDICT_VERSION;
                end else if (n_ihl < MIN_IHL) begin
                    hit     = 1'b1;
                    verdict = VERDICT_HEADLEN;
                end
            end

            if (!hit) begin
                if (n_count == POS_TTL && i_data_byte == 8'd0
                        && n_pending == VERDICT_ACCEPT) begin
                    n_pending = VERDICT_TTL;
                end

                if (n_count >= POS_DEST_FIRST && n_count <= POS_DEST_LAST) begin
                    n_dest = {n_dest[23:0], i_data_byte};
                    if (n_count == POS_DEST_LAST && n_pending == VERDICT_ACCEPT
                            && n_dest != i_local_address && n_dest != BCAST_ADDR) begin
                        n_pending = VERDICT_DEST;
                    end
                end

                // even byte: high half of the word, odd byte: complete word
                if (!n_count[0]) begin
                    n_high = i_data_byte;
                end else begin
                    word = {n_high, i_data_byte};
                    if (n_count == POS_CSUM_LO) begin
                        n_rxcsum = word;
                    end else begin
                        acc   = {1'b0, n_sum} + {1'b0, word};
                        n_sum = acc[15:0] + {15'd0, acc[16]};
                    end
                end

                last = {n_ihl, 2'b00} - 6'd1;
                if (n_count == last) begin
                    hit = 1'b1;
                    if (n_pending != VERDICT_ACCEPT) begin
                        verdict = n_pending;
                    end else if (~n_sum != n_rxcsum) begin
                        verdict = VERDICT_CHECKSUM;
                    end else begin
                        verdict = VERDICT_ACCEPT;
                    end
                end else begin
                    n_count = n_count + 6'd1;
                end
            end

            if (hit) begin
                n_done = 1'b1;
            end
        end

        o_push                = i_go && hit;
        o_result.verdict      = verdict;
        o_result.header_words = n_ihl;
    end

    `ASSERT_NEXT(a_done_after_push, i_clk, i_rst_n, o_push, r_done,
        "parser not idle after verdict")
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, !r_done, r_count < POS_LIMIT,
        "byte count beyond longest header")

endmodule

`default_nettype wire

### hw/rtl/ipv4hc_outbuf.sv
// ---------------------------------------------------------------------------
// IPv4 header check: result buffer
// Two-entry result queue; the parser stops only when both are taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv4hc_outbuf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire ipv4hc_pkg::t_result i_result,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire                    i_stall,
    output ipv4hc_pkg::t_result    o_result
);
    import ipv4hc_pkg::*;
    `include "assert_macros.svh"

    logic [1:0] r_cnt,  n_cnt;
    t_result    r_head, n_head;
    t_result    r_tail, n_tail;
    logic       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    always_comb begin
        pop    = (r_cnt != 2'd0) && !i_stall;
        n_cnt  = r_cnt;
        n_head = r_head;
        n_tail = r_tail;
        case ({i_push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_head = i_result;
                end else begin
                    n_tail = i_result;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_head = r_tail;
                n_cnt  = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_head = i_result;
                end else begin
                    n_head = r_tail;
                    n_tail = i_result;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_head;

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3,
        "result queue count out of range")
    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != 2'd2,
        "result pushed into full queue")

endmodule

`default_nettype wire
